@@ rtl/core/bam_pkg.sv @@
// Shared constants, codes and types of the bitap approximate matcher.
package bam_pkg;

    // Defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF = 64;
    localparam int MAX_ERRORS_DEF  = 8;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int PIDX_W   = 6;
    localparam int BYTE_W   = 8;
    localparam int PLEN_W   = 7;
    localparam int ELIM_W   = 4;
    localparam int USED_W   = 4;
    localparam int POS_W    = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_LIMIT      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSPOSITION_ON = 2'd2;

    // Input item actions
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TEXT    = 2'd2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [PLEN_W-1:0] pattern_length;
        logic [ELIM_W-1:0] error_limit;
        logic              transposition_on;
    } cfg_t;

endpackage

@@ rtl/core/bitap_approximate_matcher_core.sv @@
// Top level of the bitap approximate matcher: config registers, front end, queue, row engine.
//
//  Channel  | Signals                              | Item contents (low bit first)
//  ---------+--------------------------------------+----------------------------------------
//  input    | s_tvalid s_tready s_tuser s_tdata    | tuser: action; tdata: pattern_index,
//           |                                      |   byte_value
//  result   | m_tvalid m_tready m_tuser m_tdata    | tuser: status; tdata: match,
//           |                                      |   errors_used, end_position
//  config   | wr_en wr_index wr_data               | 0 pattern_length, 1 error_limit,
//           |                                      |   2 transposition_on
//
//  Flow: the front end takes one item per cycle while the queue has room. A pattern
//  load finishes in the front end. A restart is done when the row engine pops it; a text
//  byte is popped, then rows 0..error_limit are updated in turn, or it is only popped
//  and flagged when the configuration is bad. The row engine is the limit.
//  Reset: rows all ones, position zero, result slot empty; pattern bytes are not cleared.
//  Stalls: a waiting result holds the row engine at its next pop; the queue keeps the
//  front end taking items until it fills.
module bitap_approximate_matcher_core #(
    parameter int PATTERN_MAX = bam_pkg::PATTERN_MAX_DEF,
    parameter int MAX_ERRORS  = bam_pkg::MAX_ERRORS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bam_pkg::ACTION_W-1:0]    s_tuser,   // [1:0] action
    input  logic [15:0]                     s_tdata,   // [5:0] pattern_index, [13:6] byte_value
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_tuser,   // [0] status
    output logic [39:0]                     m_tdata,   // [0] match, [4:1] errors_used,
                                                       // [36:5] end_position
    // configuration writes
    input  logic                            wr_en,
    input  logic [bam_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [bam_pkg::CFG_DATA_W-1:0]  wr_data
);

    localparam int QW = PATTERN_MAX + 1;   // restart flag over the byte mask

    // Configuration registers
    logic [bam_pkg::PLEN_W-1:0] pattern_length_reg;
    logic [bam_pkg::ELIM_W-1:0] error_limit_reg;
    logic                       transposition_on_reg;
    bam_pkg::cfg_t              cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg   <= '0;
            error_limit_reg      <= '0;
            transposition_on_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                bam_pkg::REG_PATTERN_LENGTH:
                begin
                    pattern_length_reg <= wr_data[bam_pkg::PLEN_W-1:0];
                end
                bam_pkg::REG_ERROR_LIMIT:
                begin
                    error_limit_reg <= wr_data[bam_pkg::ELIM_W-1:0];
                end
                bam_pkg::REG_TRANSPOSITION_ON:
                begin
                    transposition_on_reg <= wr_data[0];
                end
                default:
                begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    assign cfg.pattern_length   = pattern_length_reg;
    assign cfg.error_limit      = error_limit_reg;
    assign cfg.transposition_on = transposition_on_reg;

    // Front end -> queue -> row engine
    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          q_valid;
    logic          q_ready;
    logic [QW-1:0] q_data;

    logic                         res_match;
    logic [bam_pkg::USED_W-1:0]   res_used;
    logic [bam_pkg::POS_W-1:0]    res_pos;

    bam_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk           (clk),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .action        (s_tuser),
        .pattern_index (s_tdata[5:0]),
        .byte_value    (s_tdata[13:6]),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    bam_queue #(
        .WIDTH (QW),
        .DEPTH (bam_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    bam_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .MAX_ERRORS  (MAX_ERRORS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .match        (res_match),
        .errors_used  (res_used),
        .end_position (res_pos),
        .status       (m_tuser)
    );

    // Result packing, padded to whole bytes
    assign m_tdata = {3'b000, res_pos, res_used, res_match};

endmodule

@@ rtl/core/bam_front.sv @@
// Front end: takes items, keeps the pattern cells, builds the per-byte match mask.
module bam_front #(
    parameter int PATTERN_MAX = bam_pkg::PATTERN_MAX_DEF
) (
    input  logic                         clk,
    input  bam_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bam_pkg::ACTION_W-1:0] action,
    input  logic [bam_pkg::PIDX_W-1:0]   pattern_index,
    input  logic [bam_pkg::BYTE_W-1:0]   byte_value,
    output logic                         push_valid,
    input  logic                         push_ready,
    output logic [PATTERN_MAX:0]         push_data    // {restart flag, mask}
);

    localparam int PW = $clog2(PATTERN_MAX);

    // One pattern cell per position, each compared in place with the text byte
    logic [bam_pkg::BYTE_W-1:0] pattern_reg [PATTERN_MAX];

    logic                   accept;
    logic                   is_restart;
    logic                   is_text;
    logic [PATTERN_MAX-1:0] mask;

    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign is_restart = (action == bam_pkg::ACT_RESTART);
    assign is_text    = (action == bam_pkg::ACT_TEXT);

    always_ff @(posedge clk)
    begin
        if (accept && action == bam_pkg::ACT_LOAD && 32'(pattern_index) < PATTERN_MAX)
        begin
            pattern_reg[PW'(pattern_index)] <= byte_value;
        end
    end

    // Bit i low where pattern byte i is in use and equals the text byte
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            mask[i] = !((i < int'(cfg.pattern_length)) && (pattern_reg[i] == byte_value));
        end
    end

    // Loads and unused codes finish here; restarts and text bytes go on
    assign push_valid = in_valid && (is_restart || is_text);
    assign push_data  = {is_restart, mask};

endmodule

@@ rtl/core/bam_queue.sv @@
// Small FIFO between the front end and the row engine.
module bam_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bam_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = data_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/core/bam_back.sv @@
// Row engine: updates one error row per cycle and holds the result register.
module bam_back #(
    parameter int PATTERN_MAX = bam_pkg::PATTERN_MAX_DEF,
    parameter int MAX_ERRORS  = bam_pkg::MAX_ERRORS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bam_pkg::cfg_t              cfg,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  logic [PATTERN_MAX:0]       q_data,      // {restart flag, mask}
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       match,
    output logic [bam_pkg::USED_W-1:0] errors_used,
    output logic [bam_pkg::POS_W-1:0]  end_position,
    output logic                       status
);

    localparam int KW = $clog2(MAX_ERRORS + 1);
    localparam int EW = (MAX_ERRORS > 1) ? $clog2(MAX_ERRORS) : 1;
    localparam int PW = $clog2(PATTERN_MAX);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ROW  = 1'b1;

    logic                      state_reg, state_next;
    logic [KW-1:0]             k_reg, k_next;
    logic                      first_reg;
    logic [bam_pkg::POS_W-1:0] text_pos_reg;
    logic                      found_reg;
    logic [bam_pkg::USED_W-1:0] used_reg;
    logic                      out_valid_reg;

    logic [PATTERN_MAX-1:0] rows_reg    [MAX_ERRORS + 1];
    logic [PATTERN_MAX-1:0] earlier_reg [MAX_ERRORS];
    logic [PATTERN_MAX-1:0] prev_reg;      // old row k-1
    logic [PATTERN_MAX-1:0] newprev_reg;   // new row k-1
    logic [PATTERN_MAX-1:0] mask_reg;

    logic                      match_reg;
    logic [bam_pkg::USED_W-1:0] used_out_reg;
    logic [bam_pkg::POS_W-1:0] end_pos_reg;
    logic                      status_reg;

    logic                   pop;
    logic                   pop_restart;
    logic                   pop_text;
    logic                   cfg_bad;
    logic                   pop_bad;
    logic                   pop_run;
    logic                   in_row;
    logic                   last_row;
    logic                   finish;
    logic [PATTERN_MAX-1:0] cur;
    logic [PATTERN_MAX-1:0] ear;
    logic [PATTERN_MAX-1:0] q_term;
    logic [PATTERN_MAX-1:0] t_term;
    logic [PATTERN_MAX-1:0] new_row;
    logic                   hit;
    logic [EW-1:0]          ear_idx;
    logic [bam_pkg::USED_W-1:0] k_used;

    // Pop only with the result slot free, so a run never meets a full slot
    assign q_ready     = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign pop         = q_valid && q_ready;
    assign pop_restart = pop && q_data[PATTERN_MAX];
    assign pop_text    = pop && !q_data[PATTERN_MAX];

    assign cfg_bad = (cfg.pattern_length == '0)
                  || (32'(cfg.pattern_length) > PATTERN_MAX)
                  || (32'(cfg.error_limit) > MAX_ERRORS)
                  || (cfg.transposition_on
                      && (bam_pkg::PLEN_W'(cfg.error_limit) > (cfg.pattern_length >> 1)));

    assign pop_bad = pop_text && cfg_bad;
    assign pop_run = pop_text && !cfg_bad;

    // One row step
    assign in_row   = (state_reg == ST_ROW);
    assign last_row = (32'(k_reg) == 32'(cfg.error_limit));
    assign finish   = in_row && last_row;
    assign ear_idx  = EW'(k_reg - 1'b1);
    assign cur      = rows_reg[k_reg];
    assign ear      = earlier_reg[ear_idx];
    assign q_term   = (cur << 1) | mask_reg;
    assign t_term   = (cfg.transposition_on && !first_reg) ? (q_term & (ear << 2)) : '1;
    assign new_row  = (k_reg == '0) ? q_term
                    : (q_term & prev_reg & (newprev_reg << 1) & (prev_reg << 1) & t_term);
    assign hit      = !new_row[PW'(cfg.pattern_length - 1'b1)];
    assign k_used   = bam_pkg::USED_W'(k_reg);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_run)
                begin
                    state_next = ST_ROW;
                    k_next     = '0;
                end
            end
            ST_ROW:
            begin
                if (last_row)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            first_reg     <= 1'b1;
            text_pos_reg  <= '0;
            found_reg     <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= MAX_ERRORS; i++)
            begin
                rows_reg[i] <= '1;
            end
            for (int i = 0; i < MAX_ERRORS; i++)
            begin
                earlier_reg[i] <= '1;
            end
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;

            if (pop_bad || finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (pop_restart)
            begin
                text_pos_reg <= '0;
                first_reg    <= 1'b1;
                for (int i = 0; i <= MAX_ERRORS; i++)
                begin
                    rows_reg[i] <= '1;
                end
                for (int i = 0; i < MAX_ERRORS; i++)
                begin
                    earlier_reg[i] <= '1;
                end
            end

            if (pop_text && text_pos_reg != '1)
            begin
                text_pos_reg <= text_pos_reg + 1'b1;
            end

            if (pop_run)
            begin
                found_reg <= 1'b0;
                used_reg  <= '0;
            end

            if (in_row)
            begin
                rows_reg[k_reg] <= new_row;
                if (k_reg != '0)
                begin
                    earlier_reg[ear_idx] <= prev_reg;
                end
                if (!found_reg && hit)
                begin
                    found_reg <= 1'b1;
                    used_reg  <= k_used;
                end
                if (last_row)
                begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_text)
        begin
            end_pos_reg <= text_pos_reg;
        end
        if (pop_run)
        begin
            mask_reg <= q_data[PATTERN_MAX-1:0];
        end
        if (in_row)
        begin
            prev_reg    <= cur;
            newprev_reg <= new_row;
        end
        if (pop_bad)
        begin
            match_reg    <= 1'b0;
            used_out_reg <= '0;
            status_reg   <= 1'b1;
        end
        else if (finish)
        begin
            match_reg    <= found_reg || hit;
            used_out_reg <= found_reg ? used_reg : (hit ? k_used : '0);
            status_reg   <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match        = match_reg;
    assign errors_used  = used_out_reg;
    assign end_position = end_pos_reg;
    assign status       = status_reg;

    // A row run never overlaps a waiting result
    a_row_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_row |-> !out_valid_reg)
        else $error("row run with result slot occupied");

    // Bad-configuration results carry no match
    a_bad_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (!match_reg && used_out_reg == '0))
        else $error("bad configuration result reports a match");

    // A result appears only after a bad-config pop or the last row step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(pop_bad) || $past(finish)))
        else $error("result raised without a source");

    // Items leave the queue only while idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("queue popped during a row run");

endmodule

@@ verif/tb_bitap_approximate_matcher_core.sv @@
// Self-checking testbench for the bitap approximate matcher core.
module tb_bitap_approximate_matcher_core;

    localparam int PATTERN_MAX   = bam_pkg::PATTERN_MAX_DEF;
    localparam int MAX_ERRORS    = bam_pkg::MAX_ERRORS_DEF;
    localparam int ITEM_TARGET   = 1200;
    localparam int CALM_AT       = 1050;       // no idling on either side past this count
    localparam int SETTLE_CYCLES = 4 * (MAX_ERRORS + 2);
    localparam int CYCLE_LIMIT   = 400000;

    // action 3 has no meaning; the core must drop it
    localparam logic [bam_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

    // One row of the directed script. For STEP_CFG, code is the register index.
    // Rows with typed set expect a bad-configuration result at position pos.
    typedef struct packed {
        step_kind_t                 kind;
        logic [1:0]                 code;
        logic [bam_pkg::PIDX_W-1:0] idx;
        logic [bam_pkg::BYTE_W-1:0] value;
        logic                       typed;
        logic [bam_pkg::POS_W-1:0]  pos;
    } step_t;

    typedef struct packed {
        logic                       hit;
        logic [bam_pkg::USED_W-1:0] errs;
        logic [bam_pkg::POS_W-1:0]  end_pos;
        logic                       bad_cfg;
    } match_result_t;

    localparam int SCRIPT_LEN = 32;
    localparam step_t SCRIPT [SCRIPT_LEN] = '{
        // reset config has length 0: text is flagged, position still counts
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd63, 8'hFF, 1'b1, 32'd0},
        '{STEP_ITEM, ACT_UNUSED,                    6'd63, 8'hFF, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h00, 1'b1, 32'd1},
        // pattern "abcd", plus the top entry
        '{STEP_ITEM, bam_pkg::ACT_LOAD,             6'd0,  8'h61, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_LOAD,             6'd1,  8'h62, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_LOAD,             6'd2,  8'h63, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_LOAD,             6'd3,  8'h64, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_LOAD,             6'd63, 8'hFF, 1'b0, 32'd0},
        '{STEP_CFG,  bam_pkg::REG_PATTERN_LENGTH,   6'd0,  8'd4,  1'b0, 32'd0},
        '{STEP_CFG,  bam_pkg::REG_ERROR_LIMIT,      6'd0,  8'd1,  1'b0, 32'd0},
        '{STEP_CFG,  bam_pkg::REG_TRANSPOSITION_ON, 6'd0,  8'd1,  1'b0, 32'd0},
        // "acbd": one transposition; first byte has no two-back term
        '{STEP_ITEM, bam_pkg::ACT_RESTART,          6'd0,  8'h00, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd5,  8'h61, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h63, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h62, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h64, 1'b0, 32'd0},
        // error limit above the row count
        '{STEP_CFG,  bam_pkg::REG_ERROR_LIMIT,      6'd0,  8'd15, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h61, 1'b1, 32'd4},
        // transposition with limit above half the length
        '{STEP_CFG,  bam_pkg::REG_ERROR_LIMIT,      6'd0,  8'd3,  1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h61, 1'b1, 32'd5},
        // plain edit distance makes the same limit legal
        '{STEP_CFG,  bam_pkg::REG_TRANSPOSITION_ON, 6'd0,  8'd0,  1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_RESTART,          6'd0,  8'h00, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h61, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h62, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h00, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h64, 1'b0, 32'd0},
        // length beyond the store
        '{STEP_CFG,  bam_pkg::REG_PATTERN_LENGTH,   6'd0,  8'd127, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h61, 1'b1, 32'd4},
        // single-byte pattern, exact match only
        '{STEP_CFG,  bam_pkg::REG_PATTERN_LENGTH,   6'd0,  8'd1,  1'b0, 32'd0},
        '{STEP_CFG,  bam_pkg::REG_ERROR_LIMIT,      6'd0,  8'd0,  1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h61, 1'b0, 32'd0},
        '{STEP_ITEM, bam_pkg::ACT_TEXT,             6'd0,  8'h62, 1'b0, 32'd0}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bam_pkg::ACTION_W-1:0]    s_tuser;    // [1:0] action
    logic [15:0]                     s_tdata;    // [5:0] pattern_index, [13:6] byte_value
    logic                            m_tvalid;
    logic                            m_tready;
    logic                            m_tuser;    // [0] status
    logic [39:0]                     m_tdata;    // [0] match, [4:1] errors_used,
                                                 // [36:5] end_position
    logic                            wr_en;
    logic [bam_pkg::CFG_INDEX_W-1:0] wr_index;
    logic [bam_pkg::CFG_DATA_W-1:0]  wr_data;

    bitap_approximate_matcher_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Shadow of the matcher: config, pattern store, error rows, position
    // ------------------------------------------------------------------
    bam_pkg::cfg_t              cfg_shadow;
    logic [bam_pkg::BYTE_W-1:0] pat_mem   [PATTERN_MAX];
    logic [63:0]                rows      [MAX_ERRORS + 1];
    logic [63:0]                rows_back [MAX_ERRORS];     // row k-1 one byte earlier
    logic [bam_pkg::POS_W-1:0]  text_pos;
    logic                       fresh_text;                 // no byte seen since restart

    match_result_t pending_results [$];
    int            fail_count  = 0;
    int            item_count  = 0;
    int            cycle_count = 0;
    bit            calm        = 1'b0;
    bit            quiet_phase = 1'b0;             // phase with no idling at all

    // alphabet of the current phase: base byte with bit 0, bits 1:0 or all bits free
    logic [bam_pkg::BYTE_W-1:0] sym_base;
    logic [bam_pkg::BYTE_W-1:0] sym_spread;

    function automatic void restart_rows();
        for (int k = 0; k <= MAX_ERRORS; k++)
            rows[k] = '1;
        for (int k = 0; k < MAX_ERRORS; k++)
            rows_back[k] = '1;
        text_pos   = '0;
        fresh_text = 1'b1;
    endfunction

    function automatic bit config_invalid();
        int len;
        int lim;
        len = cfg_shadow.pattern_length;
        lim = cfg_shadow.error_limit;
        if (len == 0 || len > PATTERN_MAX)
            return 1'b1;
        if (lim > MAX_ERRORS)
            return 1'b1;
        return cfg_shadow.transposition_on && lim > len / 2;
    endfunction

    // One text byte through the shift-or rows; 0 in a row bit means "prefix matches".
    function automatic match_result_t advance_text(input logic [bam_pkg::BYTE_W-1:0] c);
        match_result_t r;
        logic [63:0]   hit_mask;
        logic [63:0]   carry;
        logic [63:0]   shifted;
        logic [63:0]   trans;
        logic [63:0]   nxt;
        int            len;
        int            lim;
        r         = '0;
        r.end_pos = text_pos;
        if (text_pos != '1)
            text_pos = text_pos + 1'b1;
        if (config_invalid())
        begin
            r.bad_cfg = 1'b1;
            return r;
        end
        len      = cfg_shadow.pattern_length;
        lim      = cfg_shadow.error_limit;
        hit_mask = '1;
        for (int i = 0; i < len; i++)
            if (pat_mem[i] == c)
                hit_mask[i] = 1'b0;
        carry   = rows[0];                          // old row k-1
        rows[0] = (rows[0] << 1) | hit_mask;
        for (int k = 1; k <= lim; k++)
        begin
            shifted = (rows[k] << 1) | hit_mask;
            trans   = '1;
            if (cfg_shadow.transposition_on && !fresh_text)
                trans = shifted & (rows_back[k-1] << 2);
            // replace, delete (new row k-1), insert (old row k-1)
            nxt = shifted & carry & (rows[k-1] << 1) & (carry << 1) & trans;
            rows_back[k-1] = carry;
            carry          = rows[k];
            rows[k]        = nxt;
        end
        fresh_text = 1'b0;
        for (int k = 0; k <= lim; k++)
        begin
            if (!rows[k][len-1])
            begin
                r.hit  = 1'b1;
                r.errs = bam_pkg::USED_W'(k);
                break;
            end
        end
        return r;
    endfunction

    function automatic logic [bam_pkg::BYTE_W-1:0] pick_symbol();
        return sym_base ^ (bam_pkg::BYTE_W'($urandom) & sym_spread);
    endfunction

    // ------------------------------------------------------------------
    // Drivers; inputs move on the falling edge only
    // ------------------------------------------------------------------
    task automatic send_item(input logic [bam_pkg::ACTION_W-1:0] act,
                             input logic [bam_pkg::PIDX_W-1:0] idx,
                             input logic [bam_pkg::BYTE_W-1:0] value, input bit typed,
                             input logic [bam_pkg::POS_W-1:0] typed_pos);
        int            gap;
        match_result_t r;
        gap = 0;
        if (!calm && !quiet_phase && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, value, idx};
        do
            @(posedge clk);
        while (!s_tready);
        // accepted at this edge
        case (act)
            bam_pkg::ACT_RESTART: restart_rows();
            bam_pkg::ACT_LOAD:    pat_mem[idx] = value;
            bam_pkg::ACT_TEXT:
            begin
                r = advance_text(value);
                if (typed)
                    r = '{hit: 1'b0, errs: '0, end_pos: typed_pos, bad_cfg: 1'b1};
                pending_results = {pending_results, r};
            end
            default: ;
        endcase
        if (act != ACT_UNUSED)
            item_count++;
        if (item_count >= CALM_AT)
            calm = 1'b1;
    endtask

    // Drop the input, let every result drain, then give queued restarts time to finish.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bam_pkg::CFG_INDEX_W-1:0] index,
                             input logic [bam_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(posedge clk);
        case (index)
            bam_pkg::REG_PATTERN_LENGTH:
                cfg_shadow.pattern_length = value[bam_pkg::PLEN_W-1:0];
            bam_pkg::REG_ERROR_LIMIT:
                cfg_shadow.error_limit = value[bam_pkg::ELIM_W-1:0];
            bam_pkg::REG_TRANSPOSITION_ON:
                cfg_shadow.transposition_on = value[0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // Result side: random stall bursts outside quiet phases, until the calm tail
    initial
    begin : result_ready
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && !quiet_phase && stall_left == 0 && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 19);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: in-order compare against the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        match_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing expected (end_position %0d)", m_tdata[36:5]);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("match", want.hit, m_tdata[0]);
                check_field("errors_used", want.errs, m_tdata[4:1]);
                check_field("end_position", want.end_pos, m_tdata[36:5]);
                check_field("status", want.bad_cfg, m_tuser);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int                         len;
        int                         plen;
        int                         lim;
        int                         max_lim;
        int                         budget;
        int                         sent;
        int                         edits;
        int                         p;
        bit                         transp;
        logic [bam_pkg::BYTE_W-1:0] tmp;
        logic [bam_pkg::BYTE_W-1:0] word [$];

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = '0;
        s_tdata  = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        sym_base   = '0;
        sym_spread = '0;
        cfg_shadow = '{pattern_length: '0, error_limit: '0, transposition_on: 1'b1};
        for (int i = 0; i < PATTERN_MAX; i++)
            pat_mem[i] = '0;
        restart_rows();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed script
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (SCRIPT[i].kind == STEP_CFG)
            begin
                wait_idle();
                write_reg(SCRIPT[i].code, bam_pkg::CFG_DATA_W'(SCRIPT[i].value));
            end
            else
                send_item(SCRIPT[i].code, SCRIPT[i].idx, SCRIPT[i].value,
                          SCRIPT[i].typed, SCRIPT[i].pos);
        end

        // random phases: new settings, fresh pattern, then edited copies and noise
        while (item_count < ITEM_TARGET)
        begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            transp      = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0:       len = 1;
                1:       len = PATTERN_MAX;
                2, 3:    len = $urandom_range(1, 12);
                default: len = $urandom_range(1, PATTERN_MAX);
            endcase
            max_lim = transp ? len / 2 : MAX_ERRORS;
            if (max_lim > MAX_ERRORS)
                max_lim = MAX_ERRORS;
            lim = ($urandom_range(0, 3) == 0) ? max_lim : $urandom_range(0, max_lim);
            if ($urandom_range(0, 9) == 0)
            begin
                // one of the illegal settings
                case ($urandom_range(0, 3))
                    0: len = 0;
                    1: len = $urandom_range(PATTERN_MAX + 1, 127);
                    2: lim = $urandom_range(MAX_ERRORS + 1, 15);
                    default:
                    begin
                        transp = 1'b1;
                        len    = $urandom_range(1, 14);
                        lim    = $urandom_range(len / 2 + 1, MAX_ERRORS);
                    end
                endcase
            end
            wait_idle();
            write_reg(bam_pkg::REG_PATTERN_LENGTH, bam_pkg::CFG_DATA_W'(len));
            write_reg(bam_pkg::REG_ERROR_LIMIT, bam_pkg::CFG_DATA_W'(lim));
            write_reg(bam_pkg::REG_TRANSPOSITION_ON, bam_pkg::CFG_DATA_W'(transp));

            sym_base = bam_pkg::BYTE_W'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0:       sym_spread = 8'h01;
                1:       sym_spread = 8'h03;
                default: sym_spread = 8'hFF;
            endcase

            // every entry in use gets written before any text reads it
            plen = (len > PATTERN_MAX) ? PATTERN_MAX : len;
            for (int i = 0; i < plen; i++)
                send_item(bam_pkg::ACT_LOAD, bam_pkg::PIDX_W'(i), pick_symbol(), 1'b0, '0);
            if ($urandom_range(0, 3) != 0)
                send_item(bam_pkg::ACT_RESTART, bam_pkg::PIDX_W'($urandom),
                          bam_pkg::BYTE_W'($urandom), 1'b0, '0);

            budget = $urandom_range(40, 110);
            sent   = 0;
            while (sent < budget)
            begin
                case ($urandom_range(0, 19))
                    0:
                    begin
                        send_item(bam_pkg::ACT_RESTART, bam_pkg::PIDX_W'($urandom),
                                  bam_pkg::BYTE_W'($urandom), 1'b0, '0);
                        sent++;
                    end
                    1:  send_item(ACT_UNUSED, bam_pkg::PIDX_W'($urandom),
                                  bam_pkg::BYTE_W'($urandom), 1'b0, '0);
                    2:
                    begin
                        send_item(bam_pkg::ACT_LOAD, bam_pkg::PIDX_W'($urandom),
                                  pick_symbol(), 1'b0, '0);
                        sent++;
                    end
                    3, 4, 5:
                    begin
                        send_item(bam_pkg::ACT_TEXT, bam_pkg::PIDX_W'($urandom),
                                  pick_symbol(), 1'b0, '0);
                        sent++;
                    end
                    default:
                    begin
                        // pattern copy with a few random edits
                        word = {};
                        for (int i = 0; i < plen; i++)
                            word = {word, pat_mem[i]};
                        if (plen == 0)
                            repeat (4) word = {word, pick_symbol()};
                        edits = $urandom_range(0, (lim > MAX_ERRORS ? MAX_ERRORS : lim) + 1);
                        repeat (edits)
                        begin
                            p = $urandom_range(0, word.size() - 1);
                            case ($urandom_range(0, 3))
                                0: word[p] = pick_symbol();
                                1:
                                begin
                                    if (word.size() > 1)
                                        word.delete(p);
                                end
                                2: word.insert(p, pick_symbol());
                                default:
                                begin
                                    if (p + 1 < word.size())
                                    begin
                                        tmp       = word[p];
                                        word[p]   = word[p+1];
                                        word[p+1] = tmp;
                                    end
                                end
                            endcase
                        end
                        foreach (word[i])
                            send_item(bam_pkg::ACT_TEXT, bam_pkg::PIDX_W'($urandom), word[i],
                                      1'b0, '0);
                        sent += word.size();
                    end
                endcase
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/bam_pkg.sv
rtl/core/bam_front.sv
rtl/core/bam_queue.sv
rtl/core/bam_back.sv
rtl/core/bitap_approximate_matcher_core.sv
verif/tb_bitap_approximate_matcher_core.sv
